FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL files that check their own behavior.
// Depends on nothing; the user supplies the clock and reset names clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define AC4_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define AC4_ASSERT_IMPL(label, cond, cons, msg) \
	`AC4_ASSERT(label, (cond) |-> (cons), msg)

`endif

FILE: hdl/ac4sfd_pkg.sv
// Shared types and constants of the AC-4 sync frame delineator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ac4sfd_pkg;

	localparam int BYTE_W = 8;
	localparam int SYNC_W = 16;
	localparam int SIZE_W = 24;
	localparam int TOTAL_W = 25;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PLAIN_SYNC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_SYNC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 2'd2;

	localparam logic [SYNC_W-1:0] PLAIN_SYNC_RST = 16'hAC40;
	localparam logic [SYNC_W-1:0] CRC_SYNC_RST = 16'hAC41;
	localparam logic [TOTAL_W-1:0] MAX_BYTES_RST = 25'd16777224;

	localparam logic [SYNC_W-1:0] SIZE_ESCAPE = 16'hFFFF;
	localparam logic [TOTAL_W-1:0] HEAD_PLAIN = 25'd4;
	localparam logic [TOTAL_W-1:0] HEAD_EXT = 25'd7;
	localparam logic [TOTAL_W-1:0] CRC_BYTES = 25'd2;

	typedef enum logic [2:0] {
		ROLE_HUNT = 3'd0,
		ROLE_SYNC = 3'd1,
		ROLE_SIZE = 3'd2,
		ROLE_EXT  = 3'd3,
		ROLE_PAY  = 3'd4,
		ROLE_CRC  = 3'd5
	} ac4sfd_role_t;

	typedef struct packed {
		logic [SYNC_W-1:0]  plain_sync;
		logic [SYNC_W-1:0]  crc_sync;
		logic [TOTAL_W-1:0] max_bytes;
	} ac4sfd_cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  byte_val;
		ac4sfd_role_t       role;
		logic               frame_end;
		logic [TOTAL_W-1:0] frame_total;
		logic               crc_present;
		logic               oversize;
	} ac4sfd_result_t;

endpackage

FILE: hdl/ac4_sync_frame_delineator.sv
// AC-4 sync frame delineator: tags each stream byte with its role in a sync frame.
// Each accepted byte passes the input register, then the result register, to its result beat.
// One byte per cycle unless the result output stalls; the parser state steps once per byte.
// Reset (arst_n low, asynchronous): hunting, pipeline empty, cfg registers at default values.
// Depends on ac4sfd_pkg, assert_macros.svh and the ac4sfd_* submodules.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ac4_sync_frame_delineator
	import ac4sfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TOTAL_W-1:0]   cfg_data,
	// stream input
	input  logic                 stream_valid,
	output logic                 stream_stall,
	input  logic [BYTE_W-1:0]    stream_byte,
	// result output
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [BYTE_W-1:0]    byte_out,
	output logic [2:0]           byte_role,
	output logic                 frame_end,
	output logic [TOTAL_W-1:0]   frame_total,
	output logic                 crc_present,
	output logic                 oversize
);

	ac4sfd_cfg_t    cfg;
	ac4sfd_result_t core_res;
	ac4sfd_result_t out_res;
	logic           valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic           advance;
	logic           step;

	// Configuration registers; writes are always taken.
	ac4sfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register: holds a byte while the result register is full and stalled.
	ac4sfd_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream_valid (stream_valid),
		.stream_stall (stream_stall),
		.stream_byte  (stream_byte),
		.advance      (advance),
		.valid_s1     (valid_s1),
		.byte_s1      (byte_s1)
	);

	// The parser state advances exactly when a held byte moves into the result register.
	assign step = valid_s1 && advance;

	ac4sfd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_s1 (byte_s1),
		.cfg     (cfg),
		.result  (core_res)
	);

	// Result register: a finished beat waits here while the next byte is taken in.
	ac4sfd_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (valid_s1),
		.result_d     (core_res),
		.advance      (advance),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_out   (out_res)
	);

	assign byte_out = out_res.byte_val;
	assign byte_role = out_res.role;
	assign frame_end = out_res.frame_end;
	assign frame_total = out_res.frame_total;
	assign crc_present = out_res.crc_present;
	assign oversize = out_res.oversize;

	// An oversize frame is dropped, never ended.
	`AC4_ASSERT_IMPL(a_end_not_over, result_valid, !(frame_end && oversize), "frame_end with oversize")
	// Oversize can only be flagged on a byte that completes the size.
	`AC4_ASSERT_IMPL(a_over_on_size, result_valid && oversize, (byte_role == ROLE_SIZE || byte_role == ROLE_EXT), "oversize outside size bytes")
	// Hunting bytes carry no frame information.
	`AC4_ASSERT_IMPL(a_hunt_clean, result_valid && byte_role == ROLE_HUNT, (!crc_present && frame_total == '0 && !frame_end), "hunting beat with frame data")
	// The input side stalls only behind a full, stalled result register.
	`AC4_ASSERT_IMPL(a_stall_cause, stream_stall, (result_valid && result_stall && valid_s1), "input stall without output backpressure")

endmodule

FILE: hdl/ac4sfd_cfg_regs.sv
// Configuration registers: sync words and maximum frame length.
// Depends on ac4sfd_pkg.
`timescale 1ns / 1ps
module ac4sfd_cfg_regs
	import ac4sfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TOTAL_W-1:0]   cfg_data,
	output ac4sfd_cfg_t          cfg
);

	ac4sfd_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plain_sync <= PLAIN_SYNC_RST;
			cfg_q.crc_sync <= CRC_SYNC_RST;
			cfg_q.max_bytes <= MAX_BYTES_RST;
		end else if (cfg_valid && cfg_ready) begin
			// writes to the unused index are dropped
			if (cfg_index == CFG_PLAIN_SYNC) begin
				cfg_q.plain_sync <= cfg_data[SYNC_W-1:0];
			end
			if (cfg_index == CFG_CRC_SYNC) begin
				cfg_q.crc_sync <= cfg_data[SYNC_W-1:0];
			end
			if (cfg_index == CFG_MAX_BYTES) begin
				cfg_q.max_bytes <= cfg_data;
			end
		end
	end

endmodule

FILE: hdl/ac4sfd_in_stage.sv
// Input register stage: captures one stream byte and holds it until the core takes it.
// Depends on ac4sfd_pkg.
`timescale 1ns / 1ps
module ac4sfd_in_stage
	import ac4sfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              stream_valid,
	output logic              stream_stall,
	input  logic [BYTE_W-1:0] stream_byte,
	input  logic              advance,
	output logic              valid_s1,
	output logic [BYTE_W-1:0] byte_s1
);

	logic vld_s1;
	logic [BYTE_W-1:0] dat_s1;

	// stall only when a byte is held and the core cannot move it on
	assign stream_stall = vld_s1 && !advance;
	assign valid_s1 = vld_s1;
	assign byte_s1 = dat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!stream_stall) begin
			vld_s1 <= stream_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream_valid && !stream_stall) begin
			dat_s1 <= stream_byte;
		end
	end

endmodule

FILE: hdl/ac4sfd_core.sv
// Frame parser state and per-byte classification logic.
// Depends on ac4sfd_pkg.
`timescale 1ns / 1ps
module ac4sfd_core
	import ac4sfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] byte_s1,
	input  ac4sfd_cfg_t       cfg,
	output ac4sfd_result_t    result
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_SIZE,
		PH_EXT,
		PH_BODY
	} phase_t;

	phase_t phase_q, phase_d;
	logic [BYTE_W-1:0]  prev_q, prev_d;
	logic [SIZE_W-1:0]  acc_q, acc_d;
	logic [TOTAL_W-1:0] rem_q, rem_d;
	logic               crc_q, crc_d;
	logic [1:0]         cnt_q, cnt_d;
	logic [TOTAL_W-1:0] len_q, len_d;

	logic [SYNC_W-1:0]  word;
	logic [SYNC_W-1:0]  acc16;
	logic [SIZE_W-1:0]  ext_acc;
	logic               size_done;
	logic [SIZE_W-1:0]  size_val;
	logic [TOTAL_W-1:0] head;
	logic [TOTAL_W-1:0] body_len;
	logic [TOTAL_W-1:0] total;

	assign word = {prev_q, byte_s1};
	assign acc16 = acc_q[SYNC_W-1:0] | {{(SYNC_W-BYTE_W){1'b0}}, byte_s1};
	assign ext_acc = {acc_q[SYNC_W-1:0], byte_s1};

	always_comb begin
		phase_d = phase_q;
		prev_d = prev_q;
		acc_d = acc_q;
		rem_d = rem_q;
		crc_d = crc_q;
		cnt_d = cnt_q;
		len_d = len_q;
		size_done = 1'b0;
		size_val = '0;
		head = '0;
		result.byte_val = byte_s1;
		result.role = ROLE_HUNT;
		result.frame_end = 1'b0;
		result.frame_total = '0;
		result.crc_present = 1'b0;
		result.oversize = 1'b0;

		unique case (phase_q)
			PH_SIZE: begin
				result.role = ROLE_SIZE;
				result.crc_present = crc_q;
				if (cnt_q == 2'd0) begin
					acc_d = {{(SIZE_W-SYNC_W){1'b0}}, byte_s1, {BYTE_W{1'b0}}};
					cnt_d = 2'd1;
				end else begin
					acc_d = {{(SIZE_W-SYNC_W){1'b0}}, acc16};
					cnt_d = 2'd0;
					if (acc16 == SIZE_ESCAPE) begin
						phase_d = PH_EXT;
						acc_d = '0;
					end else begin
						size_done = 1'b1;
						size_val = {{(SIZE_W-SYNC_W){1'b0}}, acc16};
						head = HEAD_PLAIN;
					end
				end
			end
			PH_EXT: begin
				result.role = ROLE_EXT;
				result.crc_present = crc_q;
				acc_d = ext_acc;
				if (cnt_q < 2'd2) begin
					cnt_d = cnt_q + 2'd1;
				end else begin
					cnt_d = 2'd0;
					size_done = 1'b1;
					size_val = ext_acc;
					head = HEAD_EXT;
				end
			end
			PH_BODY: begin
				result.crc_present = crc_q;
				result.frame_total = len_q;
				result.role = (crc_q && rem_q <= CRC_BYTES) ? ROLE_CRC : ROLE_PAY;
				if (rem_q <= 25'd1) begin
					rem_d = '0;
					result.frame_end = 1'b1;
					phase_d = PH_HUNT;
					prev_d = '0;
					cnt_d = 2'd0;
				end else begin
					rem_d = rem_q - 25'd1;
				end
			end
			PH_HUNT: begin
				prev_d = byte_s1;
				if (word == cfg.crc_sync || word == cfg.plain_sync) begin
					// CRC sync word wins when both match
					crc_d = (word == cfg.crc_sync);
					result.role = ROLE_SYNC;
					result.crc_present = crc_d;
					phase_d = PH_SIZE;
					cnt_d = 2'd0;
					acc_d = '0;
				end
			end
		endcase

		body_len = {1'b0, size_val} + (crc_q ? CRC_BYTES : '0);
		total = body_len + head;

		if (size_done) begin
			result.frame_total = total;
			if (total > cfg.max_bytes) begin
				result.oversize = 1'b1;
				phase_d = PH_HUNT;
				prev_d = '0;
				cnt_d = 2'd0;
			end else begin
				len_d = total;
				rem_d = body_len;
				if (body_len == '0) begin
					result.frame_end = 1'b1;
					phase_d = PH_HUNT;
					prev_d = '0;
					cnt_d = 2'd0;
				end else begin
					phase_d = PH_BODY;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			prev_q <= '0;
			acc_q <= '0;
			rem_q <= '0;
			crc_q <= 1'b0;
			cnt_q <= 2'd0;
			len_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			prev_q <= prev_d;
			acc_q <= acc_d;
			rem_q <= rem_d;
			crc_q <= crc_d;
			cnt_q <= cnt_d;
			len_q <= len_d;
		end
	end

endmodule

FILE: hdl/ac4sfd_out_stage.sv
// Result register: holds one classified byte until the sink takes it.
// Depends on ac4sfd_pkg.
`timescale 1ns / 1ps
module ac4sfd_out_stage
	import ac4sfd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  ac4sfd_result_t result_d,
	output logic           advance,
	output logic           result_valid,
	input  logic           result_stall,
	output ac4sfd_result_t result_out
);

	logic           valid_q;
	ac4sfd_result_t res_q;

	assign advance = !valid_q || !result_stall;
	assign result_valid = valid_q;
	assign result_out = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid) begin
			res_q <= result_d;
		end
	end

endmodule
